// File: hdl/scap_pkg.sv
// shared widths, limits and register codes for the strip chart plotter
`timescale 1ns / 1ps
package scap_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int WORST_W    = 31;
    localparam int INDEX_W    = 6;
    localparam int X_W        = 11;
    localparam int Y_W        = 10;
    localparam int TOP_W      = 31;
    localparam int LOW_W      = 8;
    localparam int VAL_W      = 16;
    localparam int FLOOR_W    = 16;
    localparam int COORD_W    = 10;
    localparam int DIFF_W     = 15;
    localparam int PROD_W     = DIFF_W + COORD_W;
    localparam int XNUM_W     = INDEX_W + COORD_W;
    localparam int DIV_STEPS  = 16;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = 32000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = -32768;

    localparam logic [FLOOR_W-1:0] RST_TIME_TOP_FLOOR = 16'd20;
    localparam logic [LOW_W-1:0]   RST_TEMP_AXIS_LOW  = 8'd20;
    localparam logic [FLOOR_W-1:0] RST_TEMP_TOP_FLOOR = 16'd60;
    localparam logic [COORD_W-1:0] RST_PLOT_LEFT_X    = 10'd8;
    localparam logic [COORD_W-1:0] RST_PLOT_WIDTH     = 10'd304;
    localparam logic [COORD_W-1:0] RST_PLOT_BOTTOM_Y  = 10'd140;
    localparam logic [COORD_W-1:0] RST_PLOT_HEIGHT    = 10'd110;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_TOP_FLOOR = 8'd0,
        CFG_TEMP_AXIS_LOW  = 8'd1,
        CFG_TEMP_TOP_FLOOR = 8'd2,
        CFG_PLOT_LEFT_X    = 8'd3,
        CFG_PLOT_WIDTH     = 8'd4,
        CFG_PLOT_BOTTOM_Y  = 8'd5,
        CFG_PLOT_HEIGHT    = 8'd6
    } t_cfg_idx;

endpackage

// File: hdl/scap_if.sv
// sample, point and register write channels
`timescale 1ns / 1ps
interface scap_in_if import scap_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [WORST_W-1:0]         worst_seen;
    logic                       temperature_mode;

    modport source (output valid, output sample, output worst_seen,
                    output temperature_mode, input ready);
    modport sink   (input valid, input sample, input worst_seen,
                    input temperature_mode, output ready);
endinterface

interface scap_out_if import scap_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [INDEX_W-1:0]      point_index;
    logic [X_W-1:0]          point_x;
    logic [Y_W-1:0]          point_y;
    logic [TOP_W-1:0]        axis_top;
    logic [LOW_W-1:0]        axis_low;
    logic signed [VAL_W-1:0] newest_value;
    logic                    last_point;

    modport source (output valid, output point_index, output point_x, output point_y,
                    output axis_top, output axis_low, output newest_value,
                    output last_point, input ready);
    modport sink   (input valid, input point_index, input point_x, input point_y,
                    input axis_top, input axis_low, input newest_value,
                    input last_point, output ready);
endinterface

interface scap_cfg_if import scap_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/strip_chart_autoscale_plotter_core.sv
// strip chart autoscale plotter: window store, axis scan and bit-serial point scaling
// the window scan reads and compares each held sample through the registered memory read
// per point: read, clamp, multiply, y and x divide one bit per cycle, output once free
// a new word is taken only when the previous frame is fully issued; register writes anytime
// synchronous active-low reset clears control, count and registers; window store is not cleared
`timescale 1ns / 1ps
module strip_chart_autoscale_plotter_core import scap_pkg::*; #(
    parameter int WINDOW_DEPTH = 60
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    scap_in_if.sink      i_in,
    scap_out_if.source   o_out,
    scap_cfg_if.sink     i_cfg
);

    localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int XD_W = $clog2(WINDOW_DEPTH);
    localparam logic [XD_W:0] X_DIV = (XD_W+1)'(WINDOW_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_HEAD,
        S_FLOOR,
        S_SPAN,
        S_PT_RD,
        S_PT_CLAMP,
        S_PT_MUL,
        S_PT_DIV,
        S_PT_OUT
    } t_state;

    t_state r_state;

    logic [FLOOR_W-1:0] r_time_top_floor;
    logic [LOW_W-1:0]   r_temp_axis_low;
    logic [FLOOR_W-1:0] r_temp_top_floor;
    logic [COORD_W-1:0] r_plot_left_x;
    logic [COORD_W-1:0] r_plot_width;
    logic [COORD_W-1:0] r_plot_bottom_y;
    logic [COORD_W-1:0] r_plot_height;

    logic [VAL_W-1:0]   r_mem [WINDOW_DEPTH];
    logic [VAL_W-1:0]   r_rdata;

    logic [AW-1:0]      r_wptr;
    logic [AW-1:0]      r_rd;
    logic [AW-1:0]      r_base;
    logic [CW-1:0]      r_held;
    logic [CW-1:0]      r_cnt;
    logic [VAL_W-1:0]   r_newest;
    logic [WORST_W-1:0] r_worst;
    logic               r_temp;
    logic [DIFF_W-1:0]  r_max;
    logic [TOP_W-1:0]   r_top;
    logic [LOW_W-1:0]   r_low;
    logic [TOP_W-1:0]   r_span;
    logic [DIFF_W-1:0]  r_diff;
    logic [TOP_W-1:0]   r_ry;
    logic [DIV_STEPS-1:0] r_ny;
    logic [XD_W-1:0]    r_rx;
    logic [XNUM_W-1:0]  r_nx;
    logic [STEP_W-1:0]  r_step;

    logic                    r_ov;
    logic [INDEX_W-1:0]      r_o_idx;
    logic [X_W-1:0]          r_o_x;
    logic [Y_W-1:0]          r_o_y;
    logic [TOP_W-1:0]        r_o_top;
    logic [LOW_W-1:0]        r_o_low;
    logic [VAL_W-1:0]        r_o_newest;
    logic                    r_o_last;

    logic               in_acc;
    logic [VAL_W-1:0]   clamped;
    logic [AW-1:0]      n_wptr;
    logic [AW-1:0]      n_rd;
    logic [CW:0]        base_w;
    logic [CW:0]        base_h;
    logic [CW:0]        base_sum;
    logic [TOP_W-1:0]   head_top;
    logic [TOP_W:0]     head_sum;
    logic [FLOOR_W-1:0] floor_sel;
    logic [TOP_W:0]     ysh;
    logic [TOP_W:0]     ysub;
    logic               yge;
    logic [XD_W:0]      xsh;
    logic               xge;
    logic [DIV_STEPS-1:0] pt_y_q;
    logic               pt_last;
    logic               out_free;
    logic [VAL_W-1:0]   pv;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if ($signed(i_in.sample) > SAMPLE_HI) begin
            clamped = SAMPLE_HI[VAL_W-1:0];
        end else if ($signed(i_in.sample) < SAMPLE_LO) begin
            clamped = SAMPLE_LO[VAL_W-1:0];
        end else begin
            clamped = i_in.sample[VAL_W-1:0];
        end
    end

    assign n_wptr = (r_wptr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_rd   = (r_rd == AW'(WINDOW_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    // oldest held entry of the circular window
    assign base_w   = (CW+1)'(r_wptr);
    assign base_h   = (CW+1)'(r_held);
    assign base_sum = (base_w >= base_h) ? (base_w - base_h)
                                         : (base_w + (CW+1)'(WINDOW_DEPTH) - base_h);

    assign head_top  = (r_worst > TOP_W'(r_max)) ? r_worst : TOP_W'(r_max);
    assign head_sum  = (TOP_W+1)'(head_top) + (TOP_W+1)'(head_top >> 2);
    assign floor_sel = r_temp ? r_temp_top_floor : r_time_top_floor;

    assign ysh  = {r_ry, r_ny[DIV_STEPS-1]};
    assign yge  = (ysh >= (TOP_W+1)'(r_span));
    assign ysub = ysh - (TOP_W+1)'(r_span);
    assign xsh  = {r_rx, r_nx[XNUM_W-1]};
    assign xge  = (xsh >= X_DIV);

    assign pt_y_q   = r_ny;
    assign pt_last  = ((r_cnt + 1'b1) == r_held);
    assign out_free = !r_ov || o_out.ready;
    assign pv       = r_rdata;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[r_wptr] <= clamped;
        end
        r_rdata <= r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_time_top_floor <= RST_TIME_TOP_FLOOR;
            r_temp_axis_low  <= RST_TEMP_AXIS_LOW;
            r_temp_top_floor <= RST_TEMP_TOP_FLOOR;
            r_plot_left_x    <= RST_PLOT_LEFT_X;
            r_plot_width     <= RST_PLOT_WIDTH;
            r_plot_bottom_y  <= RST_PLOT_BOTTOM_Y;
            r_plot_height    <= RST_PLOT_HEIGHT;
            r_wptr           <= '0;
            r_rd             <= '0;
            r_held           <= '0;
            r_cnt            <= '0;
            r_step           <= '0;
            r_ov             <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_TIME_TOP_FLOOR: r_time_top_floor <= i_cfg.data;
                    CFG_TEMP_AXIS_LOW:  r_temp_axis_low  <= i_cfg.data[LOW_W-1:0];
                    CFG_TEMP_TOP_FLOOR: r_temp_top_floor <= i_cfg.data;
                    CFG_PLOT_LEFT_X:    r_plot_left_x    <= i_cfg.data[COORD_W-1:0];
                    CFG_PLOT_WIDTH:     r_plot_width     <= i_cfg.data[COORD_W-1:0];
                    CFG_PLOT_BOTTOM_Y:  r_plot_bottom_y  <= i_cfg.data[COORD_W-1:0];
                    CFG_PLOT_HEIGHT:    r_plot_height    <= i_cfg.data[COORD_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_ov && o_out.ready && (r_state != S_PT_OUT)) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_wptr   <= n_wptr;
                        r_newest <= clamped;
                        r_worst  <= i_in.worst_seen;
                        r_temp   <= i_in.temperature_mode;
                        if (r_held != CW'(WINDOW_DEPTH)) begin
                            r_held <= r_held + 1'b1;
                        end
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_base  <= AW'(base_sum);
                    r_rd    <= AW'(base_sum);
                    r_cnt   <= '0;
                    r_max   <= '0;
                    r_state <= S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (!pv[VAL_W-1] && (pv[DIFF_W-1:0] > r_max)) begin
                        r_max <= pv[DIFF_W-1:0];
                    end
                    r_rd <= n_rd;
                    if (pt_last) begin
                        r_state <= S_HEAD;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_HEAD: begin
                    // headroom, saturating
                    r_top   <= head_sum[TOP_W] ? '1 : head_sum[TOP_W-1:0];
                    r_state <= S_FLOOR;
                end
                S_FLOOR: begin
                    if (r_top < TOP_W'(floor_sel)) begin
                        r_top <= TOP_W'(floor_sel);
                    end
                    r_low   <= r_temp ? r_temp_axis_low : '0;
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    // axis collapse
                    if (r_top <= TOP_W'(r_low)) begin
                        r_top  <= TOP_W'(r_low) + 1'b1;
                        r_span <= TOP_W'(1);
                    end else begin
                        r_span <= r_top - TOP_W'(r_low);
                    end
                    r_rd    <= r_base;
                    r_cnt   <= '0;
                    r_state <= S_PT_RD;
                end
                S_PT_RD: begin
                    r_state <= S_PT_CLAMP;
                end
                S_PT_CLAMP: begin
                    if (pv[VAL_W-1] || (pv[DIFF_W-1:0] < DIFF_W'(r_low))) begin
                        r_diff <= '0;
                    end else if (TOP_W'(pv[DIFF_W-1:0]) > r_top) begin
                        r_diff <= DIFF_W'(r_top - TOP_W'(r_low));
                    end else begin
                        r_diff <= pv[DIFF_W-1:0] - DIFF_W'(r_low);
                    end
                    r_state <= S_PT_MUL;
                end
                S_PT_MUL: begin
                    // y numerator top bits seed the remainder, low bits shift in
                    r_ry    <= TOP_W'((PROD_W'(r_diff) * PROD_W'(r_plot_height))
                                      >> DIV_STEPS);
                    r_ny    <= DIV_STEPS'(PROD_W'(r_diff) * PROD_W'(r_plot_height));
                    r_rx    <= '0;
                    r_nx    <= XNUM_W'(INDEX_W'(r_cnt)) * XNUM_W'(r_plot_width);
                    r_step  <= '0;
                    r_state <= S_PT_DIV;
                end
                S_PT_DIV: begin
                    r_ry   <= yge ? ysub[TOP_W-1:0] : ysh[TOP_W-1:0];
                    r_ny   <= {r_ny[DIV_STEPS-2:0], yge};
                    r_rx   <= xge ? XD_W'(xsh - X_DIV) : xsh[XD_W-1:0];
                    r_nx   <= {r_nx[XNUM_W-2:0], xge};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_PT_OUT;
                    end
                end
                S_PT_OUT: begin
                    if (out_free) begin
                        r_ov       <= 1'b1;
                        r_o_idx    <= INDEX_W'(r_cnt);
                        r_o_x      <= X_W'(X_W'(r_plot_left_x) + X_W'(r_nx));
                        r_o_y      <= (pt_y_q > DIV_STEPS'(r_plot_bottom_y)) ? '0
                                      : r_plot_bottom_y - Y_W'(pt_y_q);
                        r_o_top    <= r_top;
                        r_o_low    <= r_low;
                        r_o_newest <= r_newest;
                        r_o_last   <= pt_last;
                        r_rd       <= n_rd;
                        if (pt_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= S_PT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.point_index  = r_o_idx;
    assign o_out.point_x      = r_o_x;
    assign o_out.point_y      = r_o_y;
    assign o_out.axis_top     = r_o_top;
    assign o_out.axis_low     = r_o_low;
    assign o_out.newest_value = r_o_newest;
    assign o_out.last_point   = r_o_last;

endmodule
